// ===== sv/pidsc_pkg.sv =====
// Shared types and constants for the clamped-integral PID controller.
package pidsc_pkg;

  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int SUM_W   = 32;
  localparam int ADDR_W  = 5;
  localparam int APB_W   = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic        [LIMIT_W-1:0] integral_limit;
    logic        [LIMIT_W-1:0] output_limit;
  } cfg_t;

endpackage

// ===== sv/pidsc_regs.sv =====
// APB register file holding gains and limits.
module pidsc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [pidsc_pkg::APB_W-1:0]   pwdata,
  output logic [pidsc_pkg::APB_W-1:0]   prdata,
  output logic                          pready,
  output pidsc_pkg::cfg_t               cfg_o
);
  import pidsc_pkg::*;

  cfg_t     cfg_d, cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:         cfg_d.gain_p         = pwdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_d.gain_i         = pwdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_d.gain_d         = pwdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_d.integral_limit = pwdata[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_d.output_limit   = pwdata[LIMIT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:         prdata = APB_W'(unsigned'(cfg_q.gain_p));
      REG_GAIN_I:         prdata = APB_W'(unsigned'(cfg_q.gain_i));
      REG_GAIN_D:         prdata = APB_W'(unsigned'(cfg_q.gain_d));
      REG_INTEGRAL_LIMIT: prdata = APB_W'(cfg_q.integral_limit);
      REG_OUTPUT_LIMIT:   prdata = APB_W'(cfg_q.output_limit);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/pidsc_law.sv =====
// Control law: error sum update, P/I/D terms, anti-windup and output clamp.
module pidsc_law #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  pidsc_pkg::cfg_t                         cfg_i,
  input  logic signed [DATA_WIDTH:0]              err_i,
  input  logic signed [DATA_WIDTH:0]              prev_err_i,
  input  logic signed [pidsc_pkg::SUM_W-1:0]      err_sum_i,
  output logic signed [pidsc_pkg::SUM_W-1:0]      err_sum_o,
  output logic signed [DATA_WIDTH-1:0]            drive_o
);
  import pidsc_pkg::*;

  localparam int EW  = DATA_WIDTH + 1;
  localparam int SW  = ((EW > SUM_W) ? EW : SUM_W) + 1;
  localparam int IPW = GAIN_W + SUM_W;
  localparam int PW  = (DATA_WIDTH + 18 > IPW) ? DATA_WIDTH + 18 : IPW;
  localparam int TW  = PW + 2;

  localparam logic signed [SW-1:0] SUM_MAX = {{(SW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {{(SW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
  localparam logic [31:0] DMAX = (32'd1 << (DATA_WIDTH - 1)) - 32'd1;

  logic signed [SW-1:0]           sum_wide;
  logic signed [SUM_W-1:0]        sum_sat;
  logic signed [SUM_W-1:0]        acc_sum;
  logic signed [IPW-1:0]          i_prod;
  logic signed [DATA_WIDTH+16:0]  p_prod;
  logic signed [DATA_WIDTH+1:0]   d_diff;
  logic signed [DATA_WIDTH+17:0]  d_prod;
  logic signed [TW-1:0]           ilim, i_ext, i_term;
  logic        [31:0]             olim_int;
  logic signed [TW-1:0]           olim, total, total_c, shifted;
  logic                           hold;

  always_comb begin
    sum_wide = SW'(err_sum_i) + SW'(err_i);
    if (sum_wide > SUM_MAX)      sum_sat = SUM_MAX[SUM_W-1:0];
    else if (sum_wide < SUM_MIN) sum_sat = SUM_MIN[SUM_W-1:0];
    else                         sum_sat = sum_wide[SUM_W-1:0];
    acc_sum = (cfg_i.gain_i != '0) ? sum_sat : err_sum_i;
  end

  assign i_prod = cfg_i.gain_i * acc_sum;
  assign p_prod = cfg_i.gain_p * err_i;
  assign d_diff = (DATA_WIDTH+2)'(err_i) - (DATA_WIDTH+2)'(prev_err_i);
  assign d_prod = cfg_i.gain_d * d_diff;

  // anti-windup: a clamped I term drops this step's contribution to the sum
  always_comb begin
    ilim  = signed'(TW'(cfg_i.integral_limit)) <<< FRAC_BITS;
    i_ext = TW'(i_prod);
    hold  = 1'b0;
    if (i_ext >= ilim) begin
      i_term = ilim;
      hold   = 1'b1;
    end else if (i_ext <= -ilim) begin
      i_term = -ilim;
      hold   = 1'b1;
    end else begin
      i_term = i_ext;
    end
    err_sum_o = hold ? err_sum_i : acc_sum;
  end

  always_comb begin
    olim_int = (32'(cfg_i.output_limit) < DMAX) ? 32'(cfg_i.output_limit) : DMAX;
    olim     = signed'(TW'(olim_int)) <<< FRAC_BITS;
    total    = TW'(p_prod) + i_term + TW'(d_prod);
    if (total >= olim)       total_c = olim;
    else if (total <= -olim) total_c = -olim;
    else                     total_c = total;
    shifted  = total_c >>> FRAC_BITS;   // floor toward minus infinity
    drive_o  = shifted[DATA_WIDTH-1:0];
  end

endmodule

// ===== sv/pid_step_clamped_integral.sv =====
// Top level of the clamped-integral PID controller.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+----------------------
//   in      | in  | in_valid_i / in_stall_o | setpoint_i, measured_i
//   out     | out | out_valid_o / out_stall_i | drive_o
//   cfg     | in  | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// One item per cycle sustained while out_stall_i is low; an accepted item passes the
// input register, then the control law into the result register, where out_valid_o
// rises and the result can leave.
// The error-sum feedback closes through one 16x32 multiply inside that stage.
// Reset clears gains, limits, error sum and last error, and empties both stages.
// A stalled result holds in the output register; the input register still
// takes one more item, after which in_stall_o follows out_stall_i.
module pid_step_clamped_integral #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [pidsc_pkg::APB_W-1:0]   pwdata,
  output logic [pidsc_pkg::APB_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [DATA_WIDTH-1:0]  setpoint_i,
  input  logic signed [DATA_WIDTH-1:0]  measured_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]  drive_o
);
  import pidsc_pkg::*;

  cfg_t                      cfg;
  logic                      in_fire, advance, fire;
  logic                      v1_d, v1_q, v2_d, v2_q;
  logic signed [DATA_WIDTH:0] err_d, err_q;
  logic signed [DATA_WIDTH:0] prev_err_q;
  logic signed [SUM_W-1:0]   err_sum_d, err_sum_q;
  logic signed [DATA_WIDTH-1:0] drive_d, drive_q;

  pidsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidsc_law #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_law (
    .cfg_i      (cfg),
    .err_i      (err_q),
    .prev_err_i (prev_err_q),
    .err_sum_i  (err_sum_q),
    .err_sum_o  (err_sum_d),
    .drive_o    (drive_d)
  );

  assign advance    = !v2_q || !out_stall_i;
  assign fire       = v1_q && advance;
  assign in_stall_o = v1_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign err_d = (DATA_WIDTH+1)'(setpoint_i) - (DATA_WIDTH+1)'(measured_i);
  assign v1_d  = in_fire || (v1_q && !advance);
  assign v2_d  = fire || (v2_q && out_stall_i);

  assign out_valid_o = v2_q;
  assign drive_o     = drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      err_sum_q  <= '0;
      prev_err_q <= '0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      if (fire) begin
        err_sum_q  <= err_sum_d;
        prev_err_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q <= err_d;
    end
    if (fire) begin
      drive_q <= drive_d;
    end
  end

endmodule

// ===== dv/tb_pid_step_clamped_integral.sv =====
// Testbench for the clamped-integral PID controller: directed table, then random phases.
module tb_pid_step_clamped_integral;
  import pidsc_pkg::*;

  localparam int DW = 16;
  localparam int FRAC = 8;
  localparam int RUN_LIMIT = 400000;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  // Directed table row: either a full register setting or one item.
  typedef struct packed {
    row_kind_e                kind;
    logic signed [DW-1:0]     setpoint;
    logic signed [DW-1:0]     measured;
    bit                       typed;
    logic signed [DW-1:0]     want;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIMIT_W-1:0]       ilim;
    logic [LIMIT_W-1:0]       olim;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [DW-1:0] setpoint_i, measured_i, drive_o;

  // predictor copy of registers and state
  logic signed [GAIN_W-1:0] kp_c, ki_c, kd_c;
  logic [LIMIT_W-1:0] ilim_c, olim_c;
  longint err_sum, last_err;

  logic signed [DW-1:0] drive_q[$];
  logic signed [DW-1:0] drive_want;
  dir_row_t dir_q[$];
  int fail_cnt = 0;
  int sent_cnt = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int cycles = 0;

  pid_step_clamped_integral #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .setpoint_i(setpoint_i), .measured_i(measured_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .drive_o(drive_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycles, drive_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [DW-1:0] pid_drive_predict(input logic signed [DW-1:0] sp,
                                                             input logic signed [DW-1:0] ms);
    longint err, sum_next, p_t, i_t, d_t, ibound, obound, total;
    err = longint'(sp) - longint'(ms);
    sum_next = err_sum;
    // accumulate only with a nonzero integral gain
    if (ki_c != 0) begin
      sum_next = err_sum + err;
      if (sum_next > SUM_MAX) sum_next = SUM_MAX;
      if (sum_next < SUM_MIN) sum_next = SUM_MIN;
    end
    p_t = longint'(kp_c) * err;
    i_t = longint'(ki_c) * sum_next;
    d_t = longint'(kd_c) * (err - last_err);
    ibound = longint'(ilim_c) <<< FRAC;
    // anti-windup: clamped I term drops this step's error from the sum
    if (i_t >= ibound) begin
      i_t = ibound;
      sum_next = err_sum;
    end else if (i_t <= -ibound) begin
      i_t = -ibound;
      sum_next = err_sum;
    end
    err_sum = sum_next;
    // a 15-bit limit never exceeds the 16-bit drive maximum
    obound = longint'(olim_c) <<< FRAC;
    total = p_t + i_t + d_t;
    if (total >= obound) total = obound;
    else if (total <= -obound) total = -obound;
    last_err = err;
    return DW'(total >>> FRAC);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [DW-1:0] got,
                                 input logic signed [DW-1:0] want);
    $display("[%0d] %s: drive got %0d want %0d", cycles, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (drive_q.size() == 0) begin
        report_mismatch("item with nothing expected", drive_o, '0);
      end else begin
        drive_want = drive_q.pop_front();
        if (drive_o !== drive_want) report_mismatch("drive mismatch", drive_o, drive_want);
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off mid-run
  int hold_left = 0;
  bit hold_done = 1'b0;
  int pat_mode = 0;
  int pat_left = 0;
  bit pat_tog = 1'b0;
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && sent_cnt >= 600) begin
      hold_left = 300;
      hold_done = 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(10, 120);
      end
      pat_left--;
      pat_tog = ~pat_tog;
      case (pat_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= pat_tog;
      endcase
    end
  end

  // the bus returns to idle before each write ends so back-to-back calls start cleanly
  task automatic write_reg(input reg_idx_e idx, input logic [APB_W-1:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_ctrl(input logic signed [GAIN_W-1:0] kp, input logic signed [GAIN_W-1:0] ki,
                          input logic signed [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] il,
                          input logic [LIMIT_W-1:0] ol);
    write_reg(REG_GAIN_P, {16'h0, kp});
    write_reg(REG_GAIN_I, {16'h0, ki});
    write_reg(REG_GAIN_D, {16'h0, kd});
    write_reg(REG_INTEGRAL_LIMIT, {17'h0, il});
    write_reg(REG_OUTPUT_LIMIT, {17'h0, ol});
    kp_c = kp;
    ki_c = ki;
    kd_c = kd;
    ilim_c = il;
    olim_c = ol;
  endtask

  // drop valid and wait for every expected drive to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (drive_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic send_item(input logic signed [DW-1:0] sp, input logic signed [DW-1:0] ms,
                           input bit typed, input logic signed [DW-1:0] want);
    int gap;
    logic signed [DW-1:0] pred;
    if (burst_left == 0) begin
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    setpoint_i <= sp;
    measured_i <= ms;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = pid_drive_predict(sp, ms);
    drive_q.push_back(typed ? want : pred);
    sent_cnt++;
    burst_left--;
    @(negedge clk_i);
  endtask

  function automatic dir_row_t item_row(input logic signed [DW-1:0] sp,
                                        input logic signed [DW-1:0] ms,
                                        input bit typed, input logic signed [DW-1:0] want);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.setpoint = sp;
    r.measured = ms;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic signed [GAIN_W-1:0] kp,
                                       input logic signed [GAIN_W-1:0] ki,
                                       input logic signed [GAIN_W-1:0] kd,
                                       input logic [LIMIT_W-1:0] il, input logic [LIMIT_W-1:0] ol);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.kp = kp;
    r.ki = ki;
    r.kd = kd;
    r.ilim = il;
    r.olim = ol;
    return r;
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3, 4: return GAIN_W'($urandom_range(0, 1023)) - GAIN_W'(512);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 15'h7fff;
      2: return LIMIT_W'($urandom_range(1, 64));
      default: return LIMIT_W'($urandom_range(0, 32767));
    endcase
  endfunction

  initial begin
    logic signed [DW-1:0] sp, ms;
    dir_row_t r;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    setpoint_i = '0;
    measured_i = '0;
    kp_c = '0;
    ki_c = '0;
    kd_c = '0;
    ilim_c = '0;
    olim_c = '0;
    err_sum = 0;
    last_err = 0;

    // after reset: all gains and limits zero, drive stays zero
    dir_q.push_back(item_row(16'sh7fff, 16'sh8000, 1'b1, 16'sd0));
    dir_q.push_back(item_row(16'sh8000, 16'sh7fff, 1'b1, 16'sd0));
    dir_q.push_back(item_row(16'sd0, 16'sd0, 1'b1, 16'sd0));
    // unity P gain: extremes saturate at the output bound
    dir_q.push_back(cfg_row(16'sd256, 16'sd0, 16'sd0, 15'd0, 15'h7fff));
    dir_q.push_back(item_row(16'sh7fff, 16'sh8000, 1'b1, 16'sd32767));
    dir_q.push_back(item_row(16'sh8000, 16'sh7fff, 1'b1, -16'sd32767));
    dir_q.push_back(item_row(16'sd100, 16'sd300, 1'b1, -16'sd200));
    dir_q.push_back(item_row(16'sd5, 16'sd5, 1'b1, 16'sd0));
    // half gain: truncation rounds toward minus infinity
    dir_q.push_back(cfg_row(16'sd128, 16'sd0, 16'sd0, 15'd0, 15'h7fff));
    dir_q.push_back(item_row(16'sd0, 16'sd3, 1'b1, -16'sd2));
    dir_q.push_back(item_row(16'sd3, 16'sd0, 1'b1, 16'sd1));
    // zero output limit forces zero drive
    dir_q.push_back(cfg_row(16'sh8000, 16'sd0, 16'sd0, 15'd0, 15'd0));
    dir_q.push_back(item_row(16'sd1000, 16'sd0, 1'b1, 16'sd0));
    dir_q.push_back(item_row(16'sh8000, 16'sh7fff, 1'b1, 16'sd0));
    // integral clamp both ways with a small limit
    dir_q.push_back(cfg_row(16'sd0, 16'sd256, 16'sd0, 15'd10, 15'h7fff));
    repeat (4) dir_q.push_back(item_row(16'sd4, 16'sd0, 1'b0, 16'sd0));
    dir_q.push_back(item_row(16'sd0, 16'sd4, 1'b0, 16'sd0));
    repeat (2) dir_q.push_back(item_row(-16'sd100, 16'sd0, 1'b0, 16'sd0));
    // derivative on a full swing of the error
    dir_q.push_back(cfg_row(16'sd0, 16'sd0, 16'sh7fff, 15'd0, 15'h7fff));
    dir_q.push_back(item_row(16'sh7fff, 16'sh8000, 1'b0, 16'sd0));
    dir_q.push_back(item_row(16'sh8000, 16'sh7fff, 1'b0, 16'sd0));
    dir_q.push_back(item_row(16'sd0, 16'sd0, 1'b0, 16'sd0));
    // most negative gains, widest limits
    dir_q.push_back(cfg_row(16'sh8000, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff));
    dir_q.push_back(item_row(16'sh7fff, 16'sh8000, 1'b0, 16'sd0));
    dir_q.push_back(item_row(16'sd1, 16'sd0, 1'b0, 16'sd0));
    dir_q.push_back(item_row(16'sh8000, 16'sh7fff, 1'b0, 16'sd0));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_q[k]) begin
      r = dir_q[k];
      if (r.kind == ROW_CFG) begin
        drain();
        set_ctrl(r.kp, r.ki, r.kd, r.ilim, r.olim);
      end else begin
        send_item(r.setpoint, r.measured, r.typed, r.want);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      set_ctrl(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
      gaps_on = (ph % 3 != 1);
      for (int n = 0; n < 112; n++) begin
        sp = DW'($urandom);
        case ($urandom_range(0, 9))
          // mostly a tracking loop: small error around a random setpoint
          0, 1, 2, 3, 4, 5: ms = sp - DW'($urandom_range(0, 600)) + DW'(300);
          6, 7: ms = DW'($urandom);
          8: begin
            sp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            ms = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          end
          default: ms = sp;
        endcase
        send_item(sp, ms, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
